[hdl/smixh_pkg.sv]
// ----------------------------------------------------------------------------
// smixh_pkg
// Shared types and constants for the indexed SplitMix64 record hash core.
// ----------------------------------------------------------------------------
package smixh_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GEN_SEED     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_TYPE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_CLASS = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_COUNT = 8'd3;

    // Finalizer and salt constants
    localparam logic [63:0] MIX_MUL_1 = 64'hbf58_476d_1ce4_e5b9;
    localparam logic [63:0] MIX_MUL_2 = 64'h94d0_49bb_1331_11eb;
    localparam logic [63:0] GOLDEN    = 64'h9e37_79b9_7f4a_7c15;
    localparam logic [63:0] SALT_A    = 64'h4741_4c41_5859_5f41;
    localparam logic [63:0] SALT_B    = 64'h4741_4c41_5859_5f42;

    // Register stages from the lane input to the finished hash
    localparam int unsigned LANE_LAT = 5;

    typedef struct packed {
        logic [31:0] gen_seed;
        logic [7:0]  layout_type;
        logic [7:0]  layout_class;
        logic [47:0] record_count;
    } t_cfg;

endpackage

[hdl/smixh_cfg.sv]
// ----------------------------------------------------------------------------
// smixh_cfg
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module smixh_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_wr_en,
    input  logic [smixh_pkg::CFG_IDX_W-1:0]   i_wr_index,
    input  logic [smixh_pkg::CFG_DATA_W-1:0]  i_wr_data,
    output smixh_pkg::t_cfg                   o_cfg
);
    import smixh_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (i_wr_index)
                CFG_GEN_SEED:     n_cfg.gen_seed     = i_wr_data[31:0];
                CFG_LAYOUT_TYPE:  n_cfg.layout_type  = i_wr_data[7:0];
                CFG_LAYOUT_CLASS: n_cfg.layout_class = i_wr_data[7:0];
                CFG_RECORD_COUNT: n_cfg.record_count = i_wr_data[47:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hdl/smixh_mul64lo.sv]
// ----------------------------------------------------------------------------
// smixh_mul64lo
// Low 64 bits of a 64x64 product: three 32x32 partials registered, then
// summed combinationally at the output.
// ----------------------------------------------------------------------------
module smixh_mul64lo (
    input  logic        i_clk,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);
    logic [31:0] a_lo;
    logic [31:0] a_hi;
    logic [31:0] b_lo;
    logic [31:0] b_hi;
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;

    assign a_lo = i_a[31:0];
    assign a_hi = i_a[63:32];
    assign b_lo = i_b[31:0];
    assign b_hi = i_b[63:32];

    // cross terms only reach the upper word, so 32 result bits suffice
    always_ff @(posedge i_clk) begin
        r_ll <= {32'h0, a_lo} * {32'h0, b_lo};
        r_lh <= a_lo * b_hi;
        r_hl <= a_hi * b_lo;
    end

    assign o_p = r_ll + {r_lh + r_hl, 32'h0};

endmodule

[hdl/smixh_lane.sv]
// ----------------------------------------------------------------------------
// smixh_lane
// One SplitMix64 finalizer, five register stages deep, no stall.
// ----------------------------------------------------------------------------
module smixh_lane (
    input  logic        i_clk,
    input  logic [63:0] i_x,
    output logic [63:0] o_hash
);
    import smixh_pkg::*;

    logic [63:0] r_v1;
    logic [63:0] r_v3;
    logic [63:0] r_v5;
    logic [63:0] prod1;
    logic [63:0] prod2;

    always_ff @(posedge i_clk) begin
        r_v1 <= i_x ^ (i_x >> 30);
    end

    smixh_mul64lo u_mul1 (
        .i_clk (i_clk),
        .i_a   (r_v1),
        .i_b   (MIX_MUL_1),
        .o_p   (prod1)
    );

    always_ff @(posedge i_clk) begin
        r_v3 <= prod1 ^ (prod1 >> 27);
    end

    smixh_mul64lo u_mul2 (
        .i_clk (i_clk),
        .i_a   (r_v3),
        .i_b   (MIX_MUL_2),
        .o_p   (prod2)
    );

    always_ff @(posedge i_clk) begin
        r_v5 <= prod2 ^ (prod2 >> 31);
    end

    assign o_hash = r_v5;

endmodule

[hdl/indexed_splitmix_id_hash_core.sv]
// ----------------------------------------------------------------------------
// indexed_splitmix_id_hash_core
// Range-checks a signed record index and produces a record hash, a 128-bit
// salted identifier and a derived 31-bit seed through three finalizer lanes.
// ----------------------------------------------------------------------------
//  channel   | handshake                     | payload
//  ----------+-------------------------------+--------------------------------
//  input     | start, busy                   | i_record_index
//  result    | o_result_strobe               | o_index_valid, o_record_hash,
//            |                               | o_id_first_half, o_id_second_half,
//            |                               | o_derived_seed
//  config    | i_cfg_valid, o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  One transaction per cycle; each result passes through an input register,
//  five finalizer stages (two split 64-bit multiplies) and an output
//  register. busy stays low and cfg ready stays high.
//  Reset (synchronous, active low) clears cfg, valid pipe and result flags.
//  Results cannot be stalled; the pipeline never holds.
// ----------------------------------------------------------------------------
module indexed_splitmix_id_hash_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [63:0]                       i_record_index,
    output logic                              o_result_strobe,
    output logic                              o_index_valid,
    output logic [63:0]                       o_record_hash,
    output logic [63:0]                       o_id_first_half,
    output logic [63:0]                       o_id_second_half,
    output logic [30:0]                       o_derived_seed,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [smixh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smixh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import smixh_pkg::*;

    t_cfg        cfg;
    logic        accept;
    logic        in_range;
    logic [31:0] seed_b;
    logic [63:0] x_rec;
    logic [63:0] x_first;
    logic [63:0] x_second;
    logic [63:0] h_rec;
    logic [63:0] h_first;
    logic [63:0] h_second;
    logic [30:0] low31;

    logic [63:0]         r_idx;
    logic                r_vld0;
    logic                r_ok0;
    logic [LANE_LAT-1:0] r_vld_pipe;
    logic [LANE_LAT-1:0] r_ok_pipe;
    logic                r_out_stb;
    logic                r_out_ok;
    logic [63:0]         r_out_rec;
    logic [63:0]         r_out_first;
    logic [63:0]         r_out_second;
    logic [30:0]         r_out_dseed;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start & ~busy;

    smixh_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid & o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // negative indexes fail on the sign bit; the rest compare unsigned
    assign in_range = ~i_record_index[63] & (i_record_index < {16'h0, cfg.record_count});

    always_ff @(posedge i_clk) begin
        r_idx <= i_record_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
            r_ok0  <= 1'b0;
        end else begin
            r_vld0 <= accept;
            r_ok0  <= accept & in_range;
        end
    end

    assign seed_b   = cfg.gen_seed ^ {16'h0, cfg.layout_type, 8'h0}
                                   ^ {24'h0, cfg.layout_class};
    assign x_rec    = {cfg.gen_seed, 32'h0} ^ r_idx ^ GOLDEN;
    assign x_first  = {cfg.gen_seed, 32'h0} ^ r_idx ^ SALT_A ^ GOLDEN;
    assign x_second = {seed_b, 32'h0} ^ r_idx ^ SALT_B ^ GOLDEN;

    smixh_lane u_lane_rec (
        .i_clk  (i_clk),
        .i_x    (x_rec),
        .o_hash (h_rec)
    );

    smixh_lane u_lane_first (
        .i_clk  (i_clk),
        .i_x    (x_first),
        .o_hash (h_first)
    );

    smixh_lane u_lane_second (
        .i_clk  (i_clk),
        .i_x    (x_second),
        .o_hash (h_second)
    );

    // control bits ride alongside the lane stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_pipe <= '0;
            r_ok_pipe  <= '0;
        end else begin
            r_vld_pipe <= {r_vld_pipe[LANE_LAT-2:0], r_vld0};
            r_ok_pipe  <= {r_ok_pipe[LANE_LAT-2:0], r_ok0};
        end
    end

    assign low31 = h_rec[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_stb <= 1'b0;
            r_out_ok  <= 1'b0;
        end else begin
            r_out_stb <= r_vld_pipe[LANE_LAT-1];
            r_out_ok  <= r_ok_pipe[LANE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ok_pipe[LANE_LAT-1]) begin
            r_out_rec    <= h_rec;
            r_out_first  <= h_first;
            r_out_second <= h_second;
            r_out_dseed  <= (low31 == 31'h0) ? 31'h1 : low31;
        end else begin
            r_out_rec    <= '0;
            r_out_first  <= '0;
            r_out_second <= '0;
            r_out_dseed  <= '0;
        end
    end

    assign o_result_strobe  = r_out_stb;
    assign o_index_valid    = r_out_ok;
    assign o_record_hash    = r_out_rec;
    assign o_id_first_half  = r_out_first;
    assign o_id_second_half = r_out_second;
    assign o_derived_seed   = r_out_dseed;

endmodule
